FILE: hw/rtl/qrm_pkg.sv
// ============================================================================
// qrm_pkg
// Shared types and constants for the quaternion to rotation matrix core.
// ============================================================================
`default_nettype none

package qrm_pkg;

  // Word format: signed fixed point, DATA_WIDTH bits with FRAC_BITS fraction bits.
  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = 14;

  // Exact product of two components.
  localparam int PROD_W = 2 * DATA_WIDTH;
  // Exact matrix entry before rounding: four products, or twice a sum of two.
  localparam int SUM_W  = PROD_W + 3;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] quat_x;
    logic signed [DATA_WIDTH-1:0] quat_y;
    logic signed [DATA_WIDTH-1:0] quat_z;
    logic signed [DATA_WIDTH-1:0] quat_w;
  } quat_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] m00;
    logic signed [DATA_WIDTH-1:0] m01;
    logic signed [DATA_WIDTH-1:0] m02;
    logic signed [DATA_WIDTH-1:0] m10;
    logic signed [DATA_WIDTH-1:0] m11;
    logic signed [DATA_WIDTH-1:0] m12;
    logic signed [DATA_WIDTH-1:0] m20;
    logic signed [DATA_WIDTH-1:0] m21;
    logic signed [DATA_WIDTH-1:0] m22;
  } matrix_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] xx;
    logic signed [PROD_W-1:0] yy;
    logic signed [PROD_W-1:0] zz;
    logic signed [PROD_W-1:0] ww;
    logic signed [PROD_W-1:0] xy;
    logic signed [PROD_W-1:0] xz;
    logic signed [PROD_W-1:0] yz;
    logic signed [PROD_W-1:0] xw;
    logic signed [PROD_W-1:0] yw;
    logic signed [PROD_W-1:0] zw;
  } prod_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] s00;
    logic signed [SUM_W-1:0] s01;
    logic signed [SUM_W-1:0] s02;
    logic signed [SUM_W-1:0] s10;
    logic signed [SUM_W-1:0] s11;
    logic signed [SUM_W-1:0] s12;
    logic signed [SUM_W-1:0] s20;
    logic signed [SUM_W-1:0] s21;
    logic signed [SUM_W-1:0] s22;
  } sum_t;

endpackage

`default_nettype wire

FILE: hw/rtl/quaternion_to_rotation_matrix_core.sv
// A word accepted at a clock edge passes the input, product, sum and round
// registers in turn; its matrix then shows on result_o with done_o high.
// Throughput: one word per cycle; busy_o stays low, as the four-stage pipeline
// (input, products, sums, round) advances every cycle and the receiver cannot stall.
// Reset: rst_ni clears only the stage valid bits, so no stray done_o follows reset.
// ============================================================================
// quaternion_to_rotation_matrix_core
// Converts a Q2.14 quaternion (x, y, z, w) into the nine entries of its 3x3
// rotation matrix, laid out for row vectors, each rounded and saturated.
// ============================================================================
`default_nettype none

module quaternion_to_rotation_matrix_core import qrm_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  start_i,
  input  wire quat_t quat_i,
  output logic       busy_o,
  output logic       done_o,
  output matrix_t    result_o
);

  // The pipeline never holds back, so a word is taken whenever start_i is high.
  logic accept;

  // Input stage: the quaternion is registered before the multipliers so that the
  // product stage sees a clean launch from flops rather than from the port.
  logic  in_valid_q;
  quat_t in_quat_q;

  logic  prod_valid;
  prod_t prod;
  logic  sum_valid;
  sum_t  sum;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    in_quat_q <= quat_i;
  end

  // Stage two: ten exact 16 by 16 products, one multiplier each.
  qrm_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_q),
    .quat_i  (in_quat_q),
    .valid_o (prod_valid),
    .prod_o  (prod)
  );

  // Stage three: the diagonal entries sum four products with their signs, the
  // off-diagonal entries double a sum or difference of two cross products. All
  // of this is exact, so rounding happens once per entry.
  qrm_sum u_sum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prod_valid),
    .prod_i  (prod),
    .valid_o (sum_valid),
    .sum_o   (sum)
  );

  // Stage four: add half an output step, drop the fraction bits and clamp to
  // the word range. Its registers drive the result ports directly.
  qrm_round u_round (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (sum_valid),
    .sum_i    (sum),
    .valid_o  (done_o),
    .matrix_o (result_o)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/qrm_mul.sv
// ============================================================================
// qrm_mul
// Product stage: the ten exact pairwise products of the quaternion components.
// ============================================================================
`default_nettype none

module qrm_mul import qrm_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  valid_i,
  input  wire quat_t quat_i,
  output logic       valid_o,
  output prod_t      prod_o
);

  logic  valid_q;
  prod_t prod_d, prod_q;

  always_comb begin
    prod_d.xx = quat_i.quat_x * quat_i.quat_x;
    prod_d.yy = quat_i.quat_y * quat_i.quat_y;
    prod_d.zz = quat_i.quat_z * quat_i.quat_z;
    prod_d.ww = quat_i.quat_w * quat_i.quat_w;
    prod_d.xy = quat_i.quat_x * quat_i.quat_y;
    prod_d.xz = quat_i.quat_x * quat_i.quat_z;
    prod_d.yz = quat_i.quat_y * quat_i.quat_z;
    prod_d.xw = quat_i.quat_x * quat_i.quat_w;
    prod_d.yw = quat_i.quat_y * quat_i.quat_w;
    prod_d.zw = quat_i.quat_z * quat_i.quat_w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign valid_o = valid_q;
  assign prod_o  = prod_q;

endmodule

`default_nettype wire

FILE: hw/rtl/qrm_sum.sv
// ============================================================================
// qrm_sum
// Sum stage: exact unrounded value of each of the nine matrix entries.
// ============================================================================
`default_nettype none

module qrm_sum import qrm_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  valid_i,
  input  wire prod_t prod_i,
  output logic       valid_o,
  output sum_t       sum_o
);

  logic valid_q;
  sum_t sum_d, sum_q;

  logic signed [SUM_W-1:0] xx, yy, zz, ww, xy, xz, yz, xw, yw, zw;

  // Sign-extend every product to the full entry width.
  assign xx = SUM_W'(prod_i.xx);
  assign yy = SUM_W'(prod_i.yy);
  assign zz = SUM_W'(prod_i.zz);
  assign ww = SUM_W'(prod_i.ww);
  assign xy = SUM_W'(prod_i.xy);
  assign xz = SUM_W'(prod_i.xz);
  assign yz = SUM_W'(prod_i.yz);
  assign xw = SUM_W'(prod_i.xw);
  assign yw = SUM_W'(prod_i.yw);
  assign zw = SUM_W'(prod_i.zw);

  always_comb begin
    sum_d.s00 =  xx - yy - zz + ww;
    sum_d.s11 = -xx + yy - zz + ww;
    sum_d.s22 = -xx - yy + zz + ww;
    sum_d.s01 = (xy + zw) <<< 1;
    sum_d.s10 = (xy - zw) <<< 1;
    sum_d.s02 = (xz - yw) <<< 1;
    sum_d.s20 = (xz + yw) <<< 1;
    sum_d.s12 = (yz + xw) <<< 1;
    sum_d.s21 = (yz - xw) <<< 1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
  end

  assign valid_o = valid_q;
  assign sum_o   = sum_q;

endmodule

`default_nettype wire

FILE: hw/rtl/qrm_round.sv
// ============================================================================
// qrm_round
// Output stage: round each entry to nearest, ties up, and saturate to a word.
// ============================================================================
`default_nettype none

module qrm_round import qrm_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic valid_i,
  input  wire sum_t sum_i,
  output logic      valid_o,
  output matrix_t   matrix_o
);

  localparam int RND_W = SUM_W + 1 - FRAC_BITS;
  localparam logic signed [SUM_W:0] RND_HALF = (SUM_W + 1)'(1) << (FRAC_BITS - 1);

  logic    valid_q;
  matrix_t matrix_d, matrix_q;

  function automatic logic signed [DATA_WIDTH-1:0] round_sat(
    input logic signed [SUM_W-1:0] s
  );
    logic signed [SUM_W:0]   biased;
    logic signed [RND_W-1:0] shifted;
    logic                    fits;
    biased  = (SUM_W + 1)'(s) + RND_HALF;
    shifted = $signed(biased[SUM_W:FRAC_BITS]);
    // The value fits when every bit above the word's sign matches it.
    fits = (shifted[RND_W-1:DATA_WIDTH-1] == '0) || (shifted[RND_W-1:DATA_WIDTH-1] == '1);
    if (fits) begin
      round_sat = shifted[DATA_WIDTH-1:0];
    end else if (shifted[RND_W-1]) begin
      round_sat = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    end else begin
      round_sat = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    end
  endfunction

  always_comb begin
    matrix_d.m00 = round_sat(sum_i.s00);
    matrix_d.m01 = round_sat(sum_i.s01);
    matrix_d.m02 = round_sat(sum_i.s02);
    matrix_d.m10 = round_sat(sum_i.s10);
    matrix_d.m11 = round_sat(sum_i.s11);
    matrix_d.m12 = round_sat(sum_i.s12);
    matrix_d.m20 = round_sat(sum_i.s20);
    matrix_d.m21 = round_sat(sum_i.s21);
    matrix_d.m22 = round_sat(sum_i.s22);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    matrix_q <= matrix_d;
  end

  assign valid_o  = valid_q;
  assign matrix_o = matrix_q;

endmodule

`default_nettype wire

FILE: hw/rtl/qrm_checker.sv
// ============================================================================
// qrm_checker
// Port-level checks for the quaternion to rotation matrix core.
// ============================================================================
`default_nettype none

module qrm_checker import qrm_pkg::*; (
  input wire logic    clk_i,
  input wire logic    rst_ni,
  input wire logic    start_i,
  input wire quat_t   quat_i,
  input wire logic    busy_o,
  input wire logic    done_o,
  input wire matrix_t result_o
);

  // The pipeline never refuses a word.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("busy raised");

  // Every accepted word yields its matrix through the input, product, sum and round registers.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##4 done_o)
    else $error("result missing four cycles after acceptance");

  // No result appears without a matching accepted word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, 4))
    else $error("result without a matching word");

  // A zero quaternion gives the zero matrix.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (quat_i == '0)) |-> ##4 (result_o == '0))
    else $error("zero quaternion gave a nonzero matrix");

endmodule

bind quaternion_to_rotation_matrix_core qrm_checker u_qrm_checker (.*);

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking bench for the quaternion to rotation matrix core. It sends a
// directed set of quaternions and then a long random stream. Half of the
// random stream is scaled to unit length, as real poses would be. The other
// half is raw full-range or boundary words that drive the saturation paths, and small values.
// Every matrix that comes back is compared, entry by entry, with one worked
// out on the bench from exact products.
// ============================================================================

module tb_top;
  import qrm_pkg::*;

  localparam int RANDOM_WORDS = 1935;
  localparam int MAX_PRINTED  = 40;

  logic    clk_i    = 1'b0;
  logic    rst_ni   = 1'b0;
  logic    start_i  = 1'b0;
  quat_t   quat_i   = '0;
  logic    busy_o;
  logic    done_o;
  matrix_t result_o;

  quaternion_to_rotation_matrix_core uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .quat_i   (quat_i),
    .busy_o   (busy_o),
    .done_o   (done_o),
    .result_o (result_o)
  );

  // Words waiting to be sent, and the matrices (with their source words)
  // still owed by the core, oldest first.
  quat_t   pending_quats[$];
  quat_t   quats_in_flight[$];
  matrix_t expected_matrices[$];

  int unsigned words_sent       = 0;
  int unsigned matrices_checked = 0;
  int unsigned saturated_seen   = 0;
  int unsigned mismatch_count   = 0;
  int unsigned directed_words   = 0;
  int unsigned gap_left         = 0;
  int unsigned calm_left        = 0;
  int unsigned gap_pick;

  string entry_name[9] = '{"m00", "m01", "m02", "m10", "m11", "m12", "m20", "m21", "m22"};

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Rounds an exact entry (scaled by 2^(2*FRAC_BITS)) to nearest, with ties
  // going towards plus infinity, and clamps it to the word range.
  function automatic logic signed [DATA_WIDTH-1:0] round_to_word(longint exact);
    longint hi;
    longint lo;
    longint v;
    hi = (longint'(1) <<< (DATA_WIDTH - 1)) - 1;
    lo = -(longint'(1) <<< (DATA_WIDTH - 1));
    v  = (exact + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return DATA_WIDTH'(v);
  endfunction

  // The rotation matrix for row vectors, built from exact products.
  function automatic matrix_t rotation_of(quat_t q);
    longint x;
    longint y;
    longint z;
    longint w;
    matrix_t m;
    x = q.quat_x;
    y = q.quat_y;
    z = q.quat_z;
    w = q.quat_w;
    m.m00 = round_to_word(x*x - y*y - z*z + w*w);
    m.m01 = round_to_word(2 * (x*y + z*w));
    m.m02 = round_to_word(2 * (x*z - y*w));
    m.m10 = round_to_word(2 * (x*y - z*w));
    m.m11 = round_to_word(-x*x + y*y - z*z + w*w);
    m.m12 = round_to_word(2 * (y*z + x*w));
    m.m20 = round_to_word(2 * (x*z + y*w));
    m.m21 = round_to_word(2 * (y*z - x*w));
    m.m22 = round_to_word(-x*x - y*y + z*z + w*w);
    return m;
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_count++;
    // Past a few dozen lines further reports are only counted.
    if (mismatch_count <= MAX_PRINTED) $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  // Driver. A word is taken at an edge where start_i is high and busy_o low;
  // its matrix is worked out there and queued. The next word, or a gap, is then
  // put on the inputs. A word that is held off stays on the inputs untouched.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      if (start_i && !busy_o) begin
        expected_matrices.push_back(rotation_of(quat_i));
        quats_in_flight.push_back(quat_i);
        void'(pending_quats.pop_front());
        words_sent++;
      end
      if (start_i && busy_o) begin
        // Held off: keep the word where it is.
      end else if (gap_left > 0) begin
        gap_left--;
        start_i <= 1'b0;
      end else if (pending_quats.size() > 0) begin
        start_i <= 1'b1;
        quat_i  <= pending_quats[0];
        // Mostly short gaps, a few long ones, and now and then a stretch of
        // back-to-back words with no gap at all.
        if (calm_left > 0) begin
          calm_left--;
        end else begin
          gap_pick = $urandom_range(0, 99);
          if (gap_pick < 5) calm_left = $urandom_range(20, 150);
          if (gap_pick < 50) gap_left = 0;
          else if (gap_pick < 85) gap_left = $urandom_range(1, 3);
          else if (gap_pick < 97) gap_left = $urandom_range(4, 15);
          else gap_left = $urandom_range(16, 60);
        end
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // Monitor. A result is present for exactly the cycle in which done_o is
  // high, so it is taken at the edge that ends that cycle.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_matrices.size() == 0) begin
        report_mismatch($sformatf("matrix %h with no word outstanding", result_o));
      end else begin
        matrix_t want;
        quat_t   src;
        logic signed [DATA_WIDTH-1:0] got_e;
        logic signed [DATA_WIDTH-1:0] want_e;
        want = expected_matrices.pop_front();
        src  = quats_in_flight.pop_front();
        for (int i = 0; i < 9; i++) begin
          got_e  = result_o[(8 - i) * DATA_WIDTH +: DATA_WIDTH];
          want_e = want[(8 - i) * DATA_WIDTH +: DATA_WIDTH];
          if (got_e !== want_e)
            report_mismatch($sformatf("q=(%0d,%0d,%0d,%0d) %s got %0d want %0d",
                                      src.quat_x, src.quat_y, src.quat_z, src.quat_w,
                                      entry_name[i], got_e, want_e));
          if (want_e == {1'b0, {(DATA_WIDTH-1){1'b1}}} || want_e == {1'b1, {(DATA_WIDTH-1){1'b0}}})
            saturated_seen++;
        end
        matrices_checked++;
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    logic signed [DATA_WIDTH-1:0] corner[8];
    logic signed [DATA_WIDTH-1:0] c[4];
    real    a[4];
    real    norm;
    int     kind;

    corner = '{-16'sd32768, -16'sd32767, -16'sd16384, -16'sd1,
               16'sd0, 16'sd1, 16'sd16384, 16'sd32767};

    // Directed words: zero, identity, half turns about each axis, quarter
    // turns, the most negative and most positive codes (saturation), rounding
    // ties on both sides of zero in the diagonal and off-diagonal sums, a
    // non-unit quaternion and tiny values of mixed sign.
    pending_quats.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd0});
    pending_quats.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd16384});
    pending_quats.push_back('{16'sd16384, 16'sd0, 16'sd0, 16'sd0});
    pending_quats.push_back('{16'sd0, 16'sd16384, 16'sd0, 16'sd0});
    pending_quats.push_back('{16'sd0, 16'sd0, 16'sd16384, 16'sd0});
    pending_quats.push_back('{16'sd11585, 16'sd0, 16'sd0, 16'sd11585});
    pending_quats.push_back('{16'sd0, -16'sd11585, 16'sd0, 16'sd11585});
    pending_quats.push_back('{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768});
    pending_quats.push_back('{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767});
    pending_quats.push_back('{16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768});
    pending_quats.push_back('{-16'sd32768, 16'sd0, 16'sd0, 16'sd32767});
    pending_quats.push_back('{16'sd1, 16'sd4096, 16'sd0, 16'sd0});
    pending_quats.push_back('{-16'sd1, 16'sd4096, 16'sd0, 16'sd0});
    pending_quats.push_back('{16'sd64, 16'sd0, 16'sd0, 16'sd64});
    pending_quats.push_back('{16'sd64, 16'sd0, 16'sd64, 16'sd0});
    pending_quats.push_back('{16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384});
    pending_quats.push_back('{16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192});
    pending_quats.push_back('{16'sd1, -16'sd1, 16'sd1, -16'sd1});
    directed_words = pending_quats.size();

    // Random words: half unit quaternions (the normal use), the rest raw
    // full-range words, boundary codes and small values.
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      kind = $urandom_range(0, 99);
      if (kind < 50) begin
        norm = 0.0;
        for (int k = 0; k < 4; k++) begin
          a[k] = real'(int'($urandom_range(0, 65535)) - 32768);
          norm = norm + a[k] * a[k];
        end
        norm = $sqrt(norm);
        for (int k = 0; k < 4; k++)
          c[k] = (norm == 0.0) ? 16'sd0 : DATA_WIDTH'($rtoi(a[k] / norm * 16384.0));
      end else if (kind < 80) begin
        for (int k = 0; k < 4; k++) c[k] = DATA_WIDTH'($urandom_range(0, 65535));
      end else if (kind < 90) begin
        for (int k = 0; k < 4; k++) c[k] = corner[$urandom_range(0, 7)];
      end else begin
        for (int k = 0; k < 4; k++) c[k] = DATA_WIDTH'(int'($urandom_range(0, 511)) - 256);
      end
      pending_quats.push_back('{c[0], c[1], c[2], c[3]});
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_quats.size() != 0 || expected_matrices.size() != 0) @(posedge clk_i);
    // Let the pipeline drain, so that any stray result is still caught.
    repeat (10) @(posedge clk_i);

    $display("Sent %0d quaternions (%0d directed, the rest random), checked %0d matrices.",
             words_sent, directed_words, matrices_checked);
    $display("%0d checked entries were saturated; %0d mismatches.",
             saturated_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run (every word after the
  // longest gap, plus the pipeline).
  initial begin
    #5_000_000;
    $display("Timed out with %0d words unsent and %0d matrices owed.",
             pending_quats.size(), expected_matrices.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
